@@ sv/pgp_skp_pkg.sv @@
// Shared types and codes for the secret key packet parser.
package pgp_skp_pkg;

   // Event codes on the result channel
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_HEADER   = 3'd1;
   localparam logic [2:0] EV_KEY      = 3'd2;
   localparam logic [2:0] EV_MPI_BITS = 3'd3;
   localparam logic [2:0] EV_MPI_DATA = 3'd4;
   localparam logic [2:0] EV_MPI_ALL  = 3'd5;
   localparam logic [2:0] EV_ERROR    = 3'd6;

   // Latched error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_HEADER  = 2'd1;
   localparam logic [1:0] ERR_UNSUPP  = 2'd2;
   localparam logic [1:0] ERR_EARLY   = 2'd3;

   // One request: a message byte and its end marker
   typedef struct packed {
      logic [7:0] msg_byte;
      logic       last_byte;
   } req_type;

   // One response per request
   typedef struct packed {
      logic [2:0]  event_res;
      logic [4:0]  packet_type;
      logic        new_format;
      logic [31:0] content_length;
      logic [31:0] creation_time;
      logic [7:0]  key_algo;
      logic [1:0]  mpi_index;
      logic [15:0] mpi_bit_count;
      logic [7:0]  data_byte;
      logic [1:0]  error_code;
   } rsp_type;

   // Configuration seen by the parser
   typedef struct packed {
      logic [7:0] key_version;
      logic [7:0] key_algorithm;
   } cfg_type;

endpackage

@@ sv/pgp_skp_csr.sv @@
// Configuration registers behind the APB-style port.
module pgp_skp_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output pgp_skp_pkg::cfg_type cfg
);
   import pgp_skp_pkg::*;

   localparam logic REG_KEY_VERSION   = 1'b0;
   localparam logic REG_KEY_ALGORITHM = 1'b1;

   logic [7:0] key_version_ff, key_version_in;
   logic [7:0] key_algorithm_ff, key_algorithm_in;
   logic       wr_en;
   logic       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   // Register write decode
   always_comb begin
      key_version_in   = key_version_ff;
      key_algorithm_in = key_algorithm_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_KEY_VERSION:   key_version_in   = csr_pwdata[7:0];
            REG_KEY_ALGORITHM: key_algorithm_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_version_ff   <= 8'd4;
         key_algorithm_ff <= 8'd17;
      end else begin
         key_version_ff   <= key_version_in;
         key_algorithm_ff <= key_algorithm_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_sel)
         REG_KEY_VERSION:   csr_prdata = {24'd0, key_version_ff};
         REG_KEY_ALGORITHM: csr_prdata = {24'd0, key_algorithm_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   assign cfg.key_version   = key_version_ff;
   assign cfg.key_algorithm = key_algorithm_ff;

endmodule

@@ sv/pgp_skp_core.sv @@
// Parser state registers and the per-byte next-state and response logic.
module pgp_skp_core #(
   parameter int MPI_COUNT = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  pgp_skp_pkg::req_type req,
   input  pgp_skp_pkg::cfg_type cfg,
   output pgp_skp_pkg::rsp_type rsp
);
   import pgp_skp_pkg::*;

   localparam int MCW = (MPI_COUNT > 1) ? $clog2(MPI_COUNT) : 1;

   // Parse phases
   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_OLDLEN  = 4'd1;
   localparam logic [3:0] PH_NEWLEN1 = 4'd2;
   localparam logic [3:0] PH_NEWLEN2 = 4'd3;
   localparam logic [3:0] PH_NEWLEN4 = 4'd4;
   localparam logic [3:0] PH_VERSION = 4'd5;
   localparam logic [3:0] PH_TIME    = 4'd6;
   localparam logic [3:0] PH_ALGO    = 4'd7;
   localparam logic [3:0] PH_BITS    = 4'd8;
   localparam logic [3:0] PH_DATA    = 4'd9;
   localparam logic [3:0] PH_SKIP    = 4'd10;
   localparam logic [3:0] PH_DONE    = 4'd11;
   localparam logic [3:0] PH_ERROR   = 4'd12;

   localparam logic [4:0] TYPE_SECRET_KEY    = 5'd5;
   localparam logic [4:0] TYPE_SECRET_SUBKEY = 5'd7;

   logic [3:0]     phase_ff, phase_in;
   logic [2:0]     fcnt_ff, fcnt_in;
   logic [31:0]    len_ff, len_in;
   logic [4:0]     type_ff, type_in;
   logic           fmt_ff, fmt_in;
   logic [31:0]    time_ff, time_in;
   logic [7:0]     algo_ff, algo_in;
   logic [MCW-1:0] mpi_cnt_ff, mpi_cnt_in;
   logic [15:0]    bits_ff, bits_in;
   logic [13:0]    left_ff, left_in;
   logic [1:0]     err_ff, err_in;

   logic [7:0]     b;
   logic [2:0]     ev;
   logic [1:0]     err;
   logic [7:0]     dbyte;
   logic [MCW-1:0] idx;
   logic [3:0]     idx_wide;
   logic           mpi_last;
   logic           key_type;
   logic [16:0]    bits_round;
   logic           in_body;

   assign b        = req.msg_byte;
   assign key_type = (type_ff == TYPE_SECRET_KEY) || (type_ff == TYPE_SECRET_SUBKEY);
   assign mpi_last = ((MCW + 1)'(mpi_cnt_ff) + (MCW + 1)'(1)) >= (MCW + 1)'(MPI_COUNT);

   // Next state for one message byte
   always_comb begin
      phase_in   = phase_ff;
      fcnt_in    = fcnt_ff;
      len_in     = len_ff;
      type_in    = type_ff;
      fmt_in     = fmt_ff;
      time_in    = time_ff;
      algo_in    = algo_ff;
      mpi_cnt_in = mpi_cnt_ff;
      bits_in    = bits_ff;
      left_in    = left_ff;
      err_in     = err_ff;
      ev         = EV_NONE;
      err        = ERR_NONE;
      dbyte      = 8'd0;
      idx        = mpi_cnt_ff;
      bits_round = 17'd0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (!b[7]) begin
               err = ERR_HEADER;
            end else if (b[6]) begin
               fmt_in   = 1'b1;
               type_in  = b[4:0];
               phase_in = PH_NEWLEN1;
            end else begin
               fmt_in  = 1'b0;
               type_in = {1'b0, b[5:2]};
               if (b[1:0] == 2'd3) begin
                  err = ERR_UNSUPP;
               end else begin
                  fcnt_in  = (b[1:0] == 2'd0) ? 3'd1 : ((b[1:0] == 2'd1) ? 3'd2 : 3'd4);
                  len_in   = 32'd0;
                  phase_in = PH_OLDLEN;
               end
            end
         end
         PH_OLDLEN, PH_NEWLEN4: begin
            len_in  = {len_ff[23:0], b};
            fcnt_in = fcnt_ff - 3'd1;
            if (fcnt_in == 3'd0) begin
               ev       = EV_HEADER;
               phase_in = key_type ? PH_VERSION : PH_SKIP;
            end
         end
         PH_NEWLEN1: begin
            if (b <= 8'd191) begin
               len_in   = {24'd0, b};
               ev       = EV_HEADER;
               phase_in = key_type ? PH_VERSION : PH_SKIP;
            end else if (b <= 8'd223) begin
               len_in   = {16'd0, b - 8'd192, 8'd0};
               phase_in = PH_NEWLEN2;
            end else if (b == 8'd255) begin
               len_in   = 32'd0;
               fcnt_in  = 3'd4;
               phase_in = PH_NEWLEN4;
            end else begin
               // partial body lengths are not handled
               err = ERR_UNSUPP;
            end
         end
         PH_NEWLEN2: begin
            len_in   = len_ff + {24'd0, b} + 32'd192;
            ev       = EV_HEADER;
            phase_in = key_type ? PH_VERSION : PH_SKIP;
         end
         PH_VERSION: begin
            if (b != cfg.key_version) begin
               err = ERR_UNSUPP;
            end else begin
               time_in  = 32'd0;
               fcnt_in  = 3'd4;
               phase_in = PH_TIME;
            end
         end
         PH_TIME: begin
            time_in = {time_ff[23:0], b};
            fcnt_in = fcnt_ff - 3'd1;
            if (fcnt_in == 3'd0) begin
               phase_in = PH_ALGO;
            end
         end
         PH_ALGO: begin
            algo_in = b;
            if (b != cfg.key_algorithm) begin
               err = ERR_UNSUPP;
            end else begin
               ev         = EV_KEY;
               mpi_cnt_in = '0;
               idx        = '0;
               fcnt_in    = 3'd2;
               phase_in   = PH_BITS;
            end
         end
         PH_BITS: begin
            bits_in = (fcnt_ff == 3'd2) ? {8'd0, b} : {bits_ff[7:0], b};
            fcnt_in = fcnt_ff - 3'd1;
            if (fcnt_in == 3'd0) begin
               bits_round = {1'b0, bits_in} + 17'd7;
               left_in    = bits_round[16:3];
               if (left_in == 14'd0) begin
                  if (mpi_last) begin
                     ev       = EV_MPI_ALL;
                     phase_in = PH_DONE;
                  end else begin
                     ev         = EV_MPI_BITS;
                     mpi_cnt_in = mpi_cnt_ff + 1'b1;
                     fcnt_in    = 3'd2;
                     phase_in   = PH_BITS;
                  end
               end else begin
                  ev       = EV_MPI_BITS;
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            dbyte   = b;
            left_in = left_ff - 14'd1;
            ev      = EV_MPI_DATA;
            if (left_in == 14'd0) begin
               if (mpi_last) begin
                  ev       = EV_MPI_ALL;
                  phase_in = PH_DONE;
               end else begin
                  mpi_cnt_in = mpi_cnt_ff + 1'b1;
                  fcnt_in    = 3'd2;
                  phase_in   = PH_BITS;
               end
            end
         end
         default: ;
      endcase

      // Errors; an early end only counts when no other error hit this byte
      in_body = (phase_in >= PH_OLDLEN) && (phase_in <= PH_DATA);
      if (err != ERR_NONE) begin
         err_in   = err;
         phase_in = PH_ERROR;
         ev       = EV_ERROR;
      end else if (req.last_byte && in_body) begin
         err_in = ERR_EARLY;
         ev     = EV_ERROR;
      end
      if (ev == EV_ERROR) begin
         dbyte = 8'd0;
      end
   end

   assign idx_wide = 4'(idx);

   // Response reflects the updated state before the end-of-message restart
   assign rsp.event_res      = ev;
   assign rsp.packet_type    = type_in;
   assign rsp.new_format     = fmt_in;
   assign rsp.content_length = len_in;
   assign rsp.creation_time  = time_in;
   assign rsp.key_algo       = algo_in;
   assign rsp.mpi_index      = idx_wide[1:0];
   assign rsp.mpi_bit_count  = bits_in;
   assign rsp.data_byte      = dbyte;
   assign rsp.error_code     = err_in;

   // State registers; the last byte of a message restarts the parser
   always_ff @(posedge clock) begin
      if (reset || (step && req.last_byte)) begin
         phase_ff   <= PH_IDLE;
         fcnt_ff    <= 3'd0;
         len_ff     <= 32'd0;
         type_ff    <= 5'd0;
         fmt_ff     <= 1'b0;
         time_ff    <= 32'd0;
         algo_ff    <= 8'd0;
         mpi_cnt_ff <= '0;
         bits_ff    <= 16'd0;
         left_ff    <= 14'd0;
         err_ff     <= ERR_NONE;
      end else if (step) begin
         phase_ff   <= phase_in;
         fcnt_ff    <= fcnt_in;
         len_ff     <= len_in;
         type_ff    <= type_in;
         fmt_ff     <= fmt_in;
         time_ff    <= time_in;
         algo_ff    <= algo_in;
         mpi_cnt_ff <= mpi_cnt_in;
         bits_ff    <= bits_in;
         left_ff    <= left_in;
         err_ff     <= err_in;
      end
   end

   // Checks
   a_restart: assert property (@(posedge clock) disable iff (reset)
      step && req.last_byte |=> phase_ff == PH_IDLE && err_ff == ERR_NONE)
      else $error("parser did not restart after last byte");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      step && ev == EV_ERROR |-> err_in != ERR_NONE)
      else $error("error event without error code");

   a_data_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> left_ff != 14'd0)
      else $error("data phase with no bytes left");

   a_data_phase: assert property (@(posedge clock) disable iff (reset)
      step && ev == EV_MPI_DATA |-> phase_ff == PH_DATA)
      else $error("data event outside data phase");

endmodule

@@ sv/pgp_secret_key_packet_parser.sv @@
// Top level of the secret key packet parser: request and response registers.
//
//   port group  direction  contents
//   req_*       in         message byte and end marker, valid/stall
//   rsp_*       out        event, decoded header and key fields, valid/stall
//   csr_*       in/out     key_version at 0x0, key_algorithm at 0x4
//
// One request per cycle while rsp_stall is low; a response is valid once its
// request has passed the request register and then the parse step into the
// response register. req_stall rises only while the request register is full
// and a stalled response blocks it. Reset clears all parser state at once; the
// byte marked last_byte restarts the parser, the configuration registers stay.
module pgp_secret_key_packet_parser #(
   parameter int MPI_COUNT = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pgp_skp_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pgp_skp_pkg::rsp_type rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import pgp_skp_pkg::*;

   cfg_type cfg;
   req_type req_ff;
   rsp_type rsp_ff;
   rsp_type rsp_next;
   logic    req_v_ff, req_v_in;
   logic    rsp_v_ff, rsp_v_in;
   logic    out_free;
   logic    step;
   logic    req_take;

   pgp_skp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pgp_skp_core #(
      .MPI_COUNT (MPI_COUNT)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   // Handshake: the parse step runs when the response register can take it
   assign out_free  = !rsp_v_ff || !rsp_stall;
   assign step      = req_v_ff && out_free;
   assign req_stall = req_v_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign req_v_in = req_take || (req_v_ff && !step);
   assign rsp_v_in = step || (rsp_v_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         req_v_ff <= req_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (step) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ tb/sv/pgp_parse_checker.sv @@
// Response predictor and comparator for the secret key packet parser.
module pgp_parse_checker #(
   parameter int         MPI_COUNT     = 4,
   parameter logic [2:0] VERSION_ADDR  = 3'h0,
   parameter logic [2:0] ALGO_ADDR     = 3'h4,
   parameter logic [7:0] VERSION_RESET = 8'd4,
   parameter logic [7:0] ALGO_RESET    = 8'd17,
   parameter logic [4:0] KEY_PACKET    = 5'd5,
   parameter logic [4:0] SUBKEY_PACKET = 5'd7,
   parameter logic [1:0] OPEN_LENGTH   = 2'd3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  pgp_skp_pkg::req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  pgp_skp_pkg::rsp_type rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   input  logic                 csr_pready,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pgp_skp_pkg::*;

   // Parse phases, in stream order; the early-end check relies on this order
   typedef enum logic [3:0] {
      PS_IDLE, PS_OLDLEN, PS_NEWLEN1, PS_NEWLEN2, PS_NEWLEN4, PS_VERSION, PS_TIME,
      PS_ALGO, PS_BITS, PS_DATA, PS_SKIP, PS_DONE, PS_ERROR
   } parse_phase_type;

   parse_phase_type phase;
   logic [2:0]   fld_left;
   logic [31:0]  len_acc;
   logic [4:0]   ptype;
   logic         fmt;
   logic [31:0]  ctime;
   logic [7:0]   algo;
   logic [2:0]   mpi_no;
   logic [15:0]  bits;
   logic [13:0]  data_left;
   logic [1:0]   err_latch;
   logic [7:0]   cfg_version;
   logic [7:0]   cfg_algo;
   rsp_type      predicted_rsp[$];
   int           errors = 0;

   function automatic void clear_parse();
      phase     = PS_IDLE;
      fld_left  = '0;
      len_acc   = '0;
      ptype     = '0;
      fmt       = 1'b0;
      ctime     = '0;
      algo      = '0;
      mpi_no    = '0;
      bits      = '0;
      data_left = '0;
      err_latch = ERR_NONE;
   endfunction

   // Header complete: key packets go on to the key fields, others are skipped
   function automatic logic [2:0] body_start();
      if (ptype == KEY_PACKET || ptype == SUBKEY_PACKET) begin
         phase = PS_VERSION;
      end else begin
         phase = PS_SKIP;
      end
      return EV_HEADER;
   endfunction

   // One MPI complete: next bit count, or all done after the last one
   function automatic logic [2:0] close_mpi(input logic [2:0] ev);
      if (int'(mpi_no) + 1 >= MPI_COUNT) begin
         phase = PS_DONE;
         return EV_MPI_ALL;
      end
      mpi_no   = mpi_no + 3'd1;
      fld_left = 3'd2;
      phase    = PS_BITS;
      return ev;
   endfunction

   // Advance the parser by one message byte and form its response
   function automatic rsp_type parse_byte(input req_type rq);
      logic [7:0]  b;
      logic [2:0]  ev;
      logic [1:0]  err;
      logic [7:0]  dbyte;
      logic [2:0]  idx;
      logic [16:0] rounded;
      rsp_type     r;
      b     = rq.msg_byte;
      ev    = EV_NONE;
      err   = ERR_NONE;
      dbyte = 8'h00;
      idx   = mpi_no;
      case (phase)
         PS_IDLE: begin
            if (!b[7]) begin
               err = ERR_HEADER;
            end else if (b[6]) begin
               fmt   = 1'b1;
               ptype = b[4:0];
               phase = PS_NEWLEN1;
            end else begin
               fmt   = 1'b0;
               ptype = {1'b0, b[5:2]};
               if (b[1:0] == OPEN_LENGTH) begin
                  err = ERR_UNSUPP;
               end else begin
                  // old format length is 1, 2 or 4 bytes
                  fld_left = 3'd1 << b[1:0];
                  len_acc  = '0;
                  phase    = PS_OLDLEN;
               end
            end
         end
         PS_OLDLEN, PS_NEWLEN4: begin
            len_acc  = {len_acc[23:0], b};
            fld_left = fld_left - 3'd1;
            if (fld_left == 3'd0) ev = body_start();
         end
         PS_NEWLEN1: begin
            if (b <= 8'd191) begin
               len_acc = {24'd0, b};
               ev      = body_start();
            end else if (b <= 8'd223) begin
               len_acc = {16'd0, b - 8'd192, 8'd0};
               phase   = PS_NEWLEN2;
            end else if (b == 8'd255) begin
               len_acc  = '0;
               fld_left = 3'd4;
               phase    = PS_NEWLEN4;
            end else begin
               // partial body lengths are not supported
               err = ERR_UNSUPP;
            end
         end
         PS_NEWLEN2: begin
            len_acc = len_acc + {24'd0, b} + 32'd192;
            ev      = body_start();
         end
         PS_VERSION: begin
            if (b != cfg_version) begin
               err = ERR_UNSUPP;
            end else begin
               ctime    = '0;
               fld_left = 3'd4;
               phase    = PS_TIME;
            end
         end
         PS_TIME: begin
            ctime    = {ctime[23:0], b};
            fld_left = fld_left - 3'd1;
            if (fld_left == 3'd0) phase = PS_ALGO;
         end
         PS_ALGO: begin
            algo = b;
            if (b != cfg_algo) begin
               err = ERR_UNSUPP;
            end else begin
               ev       = EV_KEY;
               mpi_no   = '0;
               idx      = '0;
               fld_left = 3'd2;
               phase    = PS_BITS;
            end
         end
         PS_BITS: begin
            if (fld_left == 3'd2) begin
               bits = {8'd0, b};
            end else begin
               bits = {bits[7:0], b};
            end
            fld_left = fld_left - 3'd1;
            if (fld_left == 3'd0) begin
               rounded   = ({1'b0, bits} + 17'd7) >> 3;
               data_left = rounded[13:0];
               if (data_left == '0) begin
                  ev = close_mpi(EV_MPI_BITS);
               end else begin
                  ev    = EV_MPI_BITS;
                  phase = PS_DATA;
               end
            end
         end
         PS_DATA: begin
            dbyte     = b;
            data_left = data_left - 14'd1;
            if (data_left == '0) begin
               ev = close_mpi(EV_MPI_DATA);
            end else begin
               ev = EV_MPI_DATA;
            end
         end
         default: ;
      endcase

      // A detected error wins over an early end on the same byte
      if (err != ERR_NONE) begin
         err_latch = err;
         phase     = PS_ERROR;
         ev        = EV_ERROR;
      end else if (rq.last_byte && phase >= PS_OLDLEN && phase <= PS_DATA) begin
         err_latch = ERR_EARLY;
         ev        = EV_ERROR;
      end
      if (ev == EV_ERROR) dbyte = 8'h00;

      r.event_res      = ev;
      r.packet_type    = ptype;
      r.new_format     = fmt;
      r.content_length = len_acc;
      r.creation_time  = ctime;
      r.key_algo       = algo;
      r.mpi_index      = idx[1:0];
      r.mpi_bit_count  = bits;
      r.data_byte      = dbyte;
      r.error_code     = err_latch;
      if (rq.last_byte) clear_parse();
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Track configuration writes, predict each request, compare each response
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_parse();
         cfg_version = VERSION_RESET;
         cfg_algo    = ALGO_RESET;
         predicted_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               $display("%0t ns: response with none expected: %h", $time, rsp_data);
               errors++;
            end else begin
               want = predicted_rsp.pop_front();
               check_field("event_res", 32'(want.event_res), 32'(rsp_data.event_res));
               check_field("packet_type", 32'(want.packet_type), 32'(rsp_data.packet_type));
               check_field("new_format", 32'(want.new_format), 32'(rsp_data.new_format));
               check_field("content_length", want.content_length, rsp_data.content_length);
               check_field("creation_time", want.creation_time, rsp_data.creation_time);
               check_field("key_algo", 32'(want.key_algo), 32'(rsp_data.key_algo));
               check_field("mpi_index", 32'(want.mpi_index), 32'(rsp_data.mpi_index));
               check_field("mpi_bit_count", 32'(want.mpi_bit_count),
                           32'(rsp_data.mpi_bit_count));
               check_field("data_byte", 32'(want.data_byte), 32'(rsp_data.data_byte));
               check_field("error_code", 32'(want.error_code), 32'(rsp_data.error_code));
            end
         end
         if (req_valid && !req_stall) predicted_rsp.push_back(parse_byte(req_data));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == VERSION_ADDR) begin
               cfg_version = csr_pwdata[7:0];
            end else if (csr_paddr == ALGO_ADDR) begin
               cfg_algo = csr_pwdata[7:0];
            end
         end
      end
      fail_count <= errors;
      pending    <= predicted_rsp.size();
   end

endmodule

@@ tb/sv/tb_pgp_secret_key_packet_parser.sv @@
// Testbench top for the secret key packet parser: clock, reset, message stimulus, verdict.
module tb_pgp_secret_key_packet_parser;
   timeunit 1ns;
   timeprecision 1ps;
   import pgp_skp_pkg::*;

   localparam int         MPI_COUNT     = 4;
   localparam logic [2:0] CSR_KEY_VER   = 3'h0;
   localparam logic [2:0] CSR_KEY_ALGO  = 3'h4;
   localparam logic [7:0] VERSION_RESET = 8'd4;
   localparam logic [7:0] ALGO_RESET    = 8'd17;
   localparam logic [4:0] KEY_PACKET    = 5'd5;
   localparam logic [4:0] SUBKEY_PACKET = 5'd7;
   localparam logic [1:0] OPEN_LENGTH   = 2'd3;
   localparam int         PHASES        = 5;
   localparam int         PHASE_ITEMS   = 276;
   localparam int         DRAIN_CYCLES  = 4;
   localparam int         CYCLE_LIMIT   = 250000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;

   logic [7:0]  msg_bytes[$];
   logic [7:0]  cur_version;
   logic [7:0]  cur_algo;
   int          items_sent;
   int          cycles;
   bit          req_calm;
   bit          rsp_calm;

   pgp_secret_key_packet_parser #(.MPI_COUNT(MPI_COUNT)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pgp_parse_checker #(
      .MPI_COUNT     (MPI_COUNT),
      .VERSION_ADDR  (CSR_KEY_VER),
      .ALGO_ADDR     (CSR_KEY_ALGO),
      .VERSION_RESET (VERSION_RESET),
      .ALGO_RESET    (ALGO_RESET),
      .KEY_PACKET    (KEY_PACKET),
      .SUBKEY_PACKET (SUBKEY_PACKET),
      .OPEN_LENGTH   (OPEN_LENGTH)
   ) parse_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Response side: random stall before taking each response
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         hold = rsp_calm ? 0 : $urandom_range(0, 8);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic logic [7:0] rand_byte(input int lo, input int hi);
      int x;
      x = $urandom_range(hi, lo);
      return x[7:0];
   endfunction

   task automatic put_random(input int n);
      repeat (n) msg_bytes.push_back(rand_byte(0, 255));
   endtask

   // Tag and length in one of the old or new header forms
   task automatic put_header(input logic [4:0] ptype);
      int         form;
      logic [7:0] r;
      form = (ptype < 5'd16) ? $urandom_range(0, 5) : $urandom_range(3, 5);
      r    = rand_byte(0, 1);
      case (form)
         0, 1, 2: begin
            r = rand_byte(form, form);
            msg_bytes.push_back({2'b10, ptype[3:0], r[1:0]});
            put_random(1 << form);
         end
         3: begin
            msg_bytes.push_back({2'b11, r[0], ptype});
            msg_bytes.push_back(rand_byte(0, 191));
         end
         4: begin
            msg_bytes.push_back({2'b11, r[0], ptype});
            msg_bytes.push_back(rand_byte(192, 223));
            put_random(1);
         end
         default: begin
            msg_bytes.push_back({2'b11, r[0], ptype});
            msg_bytes.push_back(8'hFF);
            put_random(4);
         end
      endcase
   endtask

   // Secret key packet with matching fields, sometimes cut short or padded
   task automatic build_key_message();
      logic [15:0] nbits;
      int          x;
      int          cut_at;
      bit          cut;
      put_header(($urandom_range(0, 1) == 1) ? SUBKEY_PACKET : KEY_PACKET);
      msg_bytes.push_back(cur_version);
      put_random(4);
      msg_bytes.push_back(cur_algo);
      cut = 1'b0;
      for (int m = 0; m < MPI_COUNT && !cut; m++) begin
         case ($urandom_range(0, 15))
            0: nbits = 16'd0;
            1: begin
               // any bit count, but the message stops within a few data bytes
               x     = $urandom_range(0, 65535);
               nbits = x[15:0];
               cut   = 1'b1;
            end
            default: begin
               x     = $urandom_range(1, 48);
               nbits = x[15:0];
            end
         endcase
         msg_bytes.push_back(nbits[15:8]);
         msg_bytes.push_back(nbits[7:0]);
         put_random(cut ? $urandom_range(0, 2) : (int'(nbits) + 7) / 8);
      end
      if (!cut) begin
         if ($urandom_range(0, 6) == 0) begin
            cut_at = $urandom_range(1, msg_bytes.size() - 1);
            while (msg_bytes.size() > cut_at) void'(msg_bytes.pop_back());
         end else if ($urandom_range(0, 3) == 0) begin
            put_random($urandom_range(1, 3));
         end
      end
   endtask

   // Any packet type other than the key ones, with a short body
   task automatic build_other_message();
      logic [7:0] r;
      logic [4:0] t;
      r = rand_byte(0, 31);
      t = r[4:0];
      if (t == KEY_PACKET || t == SUBKEY_PACKET) t = t + 5'd1;
      put_header(t);
      put_random($urandom_range(0, 4));
   endtask

   // Message that fails somewhere in header or key fields; counts bytes up to the fault
   task automatic build_broken_message(output int counted);
      logic [7:0] r;
      logic [7:0] v;
      r = rand_byte(0, 255);
      case ($urandom_range(0, 4))
         0: msg_bytes.push_back({1'b0, r[6:0]});
         1: msg_bytes.push_back({2'b10, r[3:0], OPEN_LENGTH});
         2: begin
            msg_bytes.push_back({2'b11, r[5:0]});
            msg_bytes.push_back(rand_byte(224, 254));
         end
         3: begin
            put_header(r[0] ? SUBKEY_PACKET : KEY_PACKET);
            v = rand_byte(0, 255);
            if (v == cur_version) v = v + 8'd1;
            msg_bytes.push_back(v);
         end
         default: begin
            put_header(r[0] ? SUBKEY_PACKET : KEY_PACKET);
            msg_bytes.push_back(cur_version);
            put_random(4);
            v = rand_byte(0, 255);
            if (v == cur_algo) v = v + 8'd1;
            msg_bytes.push_back(v);
         end
      endcase
      counted = msg_bytes.size();
      put_random($urandom_range(0, 3));
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{msg_byte: b, last_byte: last};
      do @(posedge clock); while (req_stall);
   endtask

   // Send the built message with last_byte on its final byte
   task automatic send_message(input int counted);
      req_calm = ($urandom_range(0, 3) == 0);
      rsp_calm = ($urandom_range(0, 3) == 0);
      foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      items_sent += counted;
      msg_bytes.delete();
   endtask

   // Stop sending and wait for every outstanding response
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [7:0] value);
      logic [7:0] hi;
      hi = ($urandom_range(0, 1) == 1) ? rand_byte(0, 255) : 8'h00;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {hi, hi, hi, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int counted;
      int pick;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cycles      = 0;
      items_sent  = 0;
      req_calm    = 1'b0;
      rsp_calm    = 1'b0;
      cur_version = VERSION_RESET;
      cur_algo    = ALGO_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed messages on the reset configuration
      // tag without its top bit
      msg_bytes = '{8'h00};
      send_message(1);
      // old format with indeterminate length, also the last byte
      msg_bytes = '{{2'b10, KEY_PACKET[3:0], OPEN_LENGTH}};
      send_message(1);
      // new format partial body length, then an ignored byte
      msg_bytes = '{{3'b110, KEY_PACKET}, 8'd224, 8'h12};
      send_message(2);
      // largest two-byte length, all-ones time, zero-length MPIs, exact end
      msg_bytes = '{{3'b110, SUBKEY_PACKET}, 8'hDF, 8'hFF, VERSION_RESET,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, ALGO_RESET};
      repeat (MPI_COUNT) begin
         msg_bytes.push_back(8'h00);
         msg_bytes.push_back(8'h00);
      end
      send_message(msg_bytes.size());
      // skipped packet ending exactly on its header
      msg_bytes = '{{2'b10, 4'd2, 2'd0}, 8'hFF};
      send_message(2);
      // all-ones tag: new format, type 31, largest one-byte length
      msg_bytes = '{8'hFF, 8'd191};
      send_message(2);

      // Random messages, several register settings
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         case (p)
            0: begin cur_version = 8'h00; cur_algo = 8'h00; end
            1: begin cur_version = 8'hFF; cur_algo = 8'hFF; end
            3: begin cur_version = VERSION_RESET; cur_algo = 8'd1; end
            4: begin cur_version = rand_byte(0, 255); cur_algo = ALGO_RESET; end
            default: begin cur_version = rand_byte(0, 255); cur_algo = rand_byte(0, 255); end
         endcase
         write_csr(CSR_KEY_VER, cur_version);
         write_csr(CSR_KEY_ALGO, cur_algo);
         while (items_sent < (p + 1) * PHASE_ITEMS) begin
            if ($urandom_range(0, 39) == 0) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               build_key_message();
               counted = msg_bytes.size();
            end else if (pick < 72) begin
               build_other_message();
               counted = msg_bytes.size();
            end else if (pick < 90) begin
               build_broken_message(counted);
            end else begin
               put_random($urandom_range(1, 6));
               counted = msg_bytes.size();
            end
            send_message(counted);
         end
      end

      drain_results();
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
